// File: hdl/cst_pkg.sv
// Shared types and constants for the credential slot table.
package cst_pkg;

	localparam int DEF_SLOT_COUNT = 27;

	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 8;
	localparam int KEY_W      = 64;
	localparam int LOW_KEY_W  = 32;
	localparam int ENTRY_W    = STATUS_W + KEY_W;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 16;

	localparam logic [STATUS_W-1:0] FREE_STATUS = 8'hFF;
	localparam logic [KEY_W-1:0]    ERASED_KEY  = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum logic [MODE_W-1:0] {
		MODE_CHECK_USER  = 2'd0,
		MODE_CHECK_ADMIN = 2'd1,
		MODE_ADD_USER    = 2'd2,
		MODE_DEL_USER    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

endpackage

// File: hdl/cst_ram.sv
// Generic single-port-write, registered-read RAM.
module cst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/credential_slot_table_core.sv
// Credential slot table: slot scan sequencer, slot RAM and admin key check.
//
// Input words arrive on s_axis; one result word leaves on m_axis for each.
// The block takes one word at a time: s_axis_tready is high only while idle.
// Admin check raises m_axis_tvalid right after the accepting edge. The user
// modes scan the slot RAM one slot per cycle from slot 0 (slot 0 is read at
// the accepting edge) and raise m_axis_tvalid once the scan ends, which is
// after 1 to SLOT_COUNT slots have been visited.
// An add or delete writes its slot in the cycle the scan ends.
// The result is held on m_axis until m_axis_tready; no new word is taken
// before that handshake, so a stalled receiver stalls the input side.
// Reset clears the per-slot valid flags (every slot then reads as erased:
// status 255, key all ones) and sets the admin key to all ones; no
// clearing pass is needed. admin_key_wr_en writes the admin key, which
// should only happen while no word is in flight.
module credential_slot_table_core #(
	parameter int SLOT_COUNT = cst_pkg::DEF_SLOT_COUNT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [1:0] mode, [65:2] key, [73:66] new_status, [79:74] zero
	input  logic [cst_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [7:0] result_value, [8] table_full, [15:9] zero
	output logic [cst_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                             admin_key_wr_en,
	input  logic [cst_pkg::KEY_W-1:0]        admin_key_wr_data
);
	import cst_pkg::*;

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	state_t state_q, state_d;

	mode_t               mode_q;
	logic [KEY_W-1:0]    key_q;
	logic [STATUS_W-1:0] new_status_q;
	logic [KEY_W-1:0]    admin_key_q;
	logic [AW-1:0]       cmp_idx_q;
	logic [SLOT_COUNT-1:0] slot_valid_q;
	logic [STATUS_W-1:0] res_q, res_d;
	logic                full_q, full_d;
	logic                load_res;

	logic                s_acc;
	mode_t               in_mode;

	logic                rd_en, wr_en;
	logic [AW-1:0]       rd_addr;
	logic [ENTRY_W-1:0]  rd_data, wr_data;

	logic [STATUS_W-1:0] entry_status;
	logic [KEY_W-1:0]    entry_key;
	logic                key_hit, low_hit, is_free, is_last, found, scan_end;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign in_mode       = mode_t'(s_axis_tdata[MODE_W-1:0]);

	cst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cmp_idx_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// slot under compare; unwritten slots read as erased
	always_comb begin
		entry_status = slot_valid_q[cmp_idx_q] ? rd_data[STATUS_W-1:0] : FREE_STATUS;
		entry_key    = slot_valid_q[cmp_idx_q] ? rd_data[ENTRY_W-1:STATUS_W] : ERASED_KEY;
		key_hit      = (entry_key == key_q);
		low_hit      = (entry_key[LOW_KEY_W-1:0] == key_q[LOW_KEY_W-1:0]);
		is_free      = (entry_status == FREE_STATUS);
		is_last      = (cmp_idx_q == AW'(SLOT_COUNT - 1));
		case (mode_q)
			MODE_CHECK_USER: found = key_hit || is_free;
			MODE_ADD_USER:   found = is_free;
			MODE_DEL_USER:   found = low_hit || is_free;
			default:         found = 1'b1;
		endcase
		scan_end = found || is_last;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					state_d = (in_mode == MODE_CHECK_ADMIN) ? ST_RESP : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_data  = '0;
		load_res = 1'b0;
		res_d    = '0;
		full_d   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_en    = s_acc;
				load_res = s_acc;
				res_d    = (s_axis_tdata[MODE_W+KEY_W-1:MODE_W] == admin_key_q) ?
					STATUS_W'(1) : '0;
			end
			ST_SCAN: begin
				rd_en    = !scan_end;
				rd_addr  = cmp_idx_q + 1'b1;
				load_res = scan_end;
				full_d   = !found;
				case (mode_q)
					MODE_CHECK_USER: begin
						if (key_hit) begin
							res_d = entry_status;
						end
					end
					MODE_ADD_USER: begin
						if (is_free) begin
							wr_en   = 1'b1;
							wr_data = {key_q, new_status_q};
							res_d   = STATUS_W'(1);
						end
					end
					MODE_DEL_USER: begin
						if (low_hit) begin
							wr_en   = 1'b1;
							wr_data = '0;
							res_d   = STATUS_W'(1);
						end
					end
					default: res_d = '0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_valid_q <= '0;
			admin_key_q  <= ERASED_KEY;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				slot_valid_q[cmp_idx_q] <= 1'b1;
			end
			if (admin_key_wr_en) begin
				admin_key_q <= admin_key_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			mode_q       <= in_mode;
			key_q        <= s_axis_tdata[MODE_W+KEY_W-1:MODE_W];
			new_status_q <= s_axis_tdata[MODE_W+KEY_W+STATUS_W-1:MODE_W+KEY_W];
			cmp_idx_q    <= '0;
		end else if (state_q == ST_SCAN) begin
			cmp_idx_q <= cmp_idx_q + 1'b1;
		end
		if (load_res) begin
			res_q  <= res_d;
			full_q <= full_d;
		end
	end

	assign m_axis_tvalid = (state_q == ST_RESP);
	assign m_axis_tdata  = {{(OUT_DATA_W - STATUS_W - 1){1'b0}}, full_q, res_q};

endmodule

// File: hdl/cst_checker.sv
// Port-level assertions for the credential slot table, bound to the top level.
module cst_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [cst_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import cst_pkg::*;

	// one word in flight: never ready while a result is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while result pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("ready held after accept");

	a_idle_after_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready) |=> (s_axis_tready && !m_axis_tvalid))
		else $error("not idle after result taken");

	a_full_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[STATUS_W]) |-> (m_axis_tdata[STATUS_W-1:0] == '0))
		else $error("table_full with nonzero result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind credential_slot_table_core cst_checker u_cst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
